// ===== hdl/ebcpu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ebcpu_pkg
// Types, operation codes and constants of the 8-bit CPU execute unit.
// ----------------------------------------------------------------------------
package ebcpu_pkg;

  typedef enum logic [5:0] {
    OP_LDA, OP_LDX, OP_LDY, OP_STA, OP_STX, OP_STY, OP_TAX, OP_TAY, OP_TXA, OP_TYA,
    OP_TSX, OP_TXS, OP_PHA, OP_PHP, OP_PLA, OP_PLP,
    OP_AND, OP_EOR, OP_ORA, OP_BIT, OP_ADC, OP_SBC, OP_CMP, OP_CPX, OP_CPY,
    OP_INC, OP_INX, OP_INY, OP_DEC, OP_DEX, OP_DEY,
    OP_ASLA, OP_LSRA, OP_ROLA, OP_RORA, OP_ASLM, OP_LSRM, OP_ROLM, OP_RORM,
    OP_JMP, OP_JSR, OP_RTS,
    OP_BCC, OP_BCS, OP_BNE, OP_BEQ, OP_BPL, OP_BMI, OP_BVC, OP_BVS,
    OP_CLC, OP_CLD, OP_CLI, OP_CLV, OP_SEC, OP_SED, OP_SEI,
    OP_BRK, OP_NOP, OP_RTI
  } op_e;

  localparam int FLAG_C = 0;
  localparam int FLAG_Z = 1;
  localparam int FLAG_I = 2;
  localparam int FLAG_D = 3;
  localparam int FLAG_B = 4;
  localparam int FLAG_U = 5;
  localparam int FLAG_V = 6;
  localparam int FLAG_N = 7;

  localparam logic [7:0] STACK_PAGE     = 8'h01;
  localparam logic [7:0] SP_RESET       = 8'hFD;
  localparam logic [7:0] STATUS_RESET   = 8'h24;
  localparam logic [7:0] PUSH_FLAG_MASK = 8'h30;

  localparam logic [1:0] WRITE_NONE = 2'd0;
  localparam logic [1:0] WRITE_ONE  = 2'd1;
  localparam logic [1:0] WRITE_TWO  = 2'd2;

  typedef struct packed {
    logic [5:0]  operation;
    logic [15:0] address;
    logic [23:0] read_data;
    logic [15:0] next_pc;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  write_count;
    logic [15:0] write_address;
    logic [15:0] write_data;
    logic [7:0]  accumulator_out;
    logic [7:0]  index_x_out;
    logic [7:0]  index_y_out;
    logic [7:0]  stack_pointer_out;
    logic [7:0]  status_out;
    logic [15:0] program_counter_out;
  } res_word_t;

endpackage

// ===== hdl/ebcpu_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ebcpu_if
// Valid/ready channels for instruction words and result words.
// ----------------------------------------------------------------------------
interface ebcpu_in_if;
  import ebcpu_pkg::*;

  logic     valid;
  logic     ready;
  in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ebcpu_res_if;
  import ebcpu_pkg::*;

  logic      valid;
  logic      ready;
  res_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/eight_bit_cpu_execute_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eight_bit_cpu_execute_unit
// Execute stage of a 6502-style core: one decoded instruction per word.
// ----------------------------------------------------------------------------
// The unit accepts one instruction word per clock cycle while the result side is
// not stalled. The word is captured in an input register, executed in a single
// pass of 8-bit logic against the A, X, Y, S and P registers, and the result,
// which carries the next PC, lands in an output register while the registers
// are updated. That single execute pass, with its 9-bit add and compare, sets
// the rate of one instruction per cycle.
// Decimal mode has no effect on ADC or SBC, and BRK only sets the B flag.
module eight_bit_cpu_execute_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  ebcpu_in_if.sink    in_i,
  ebcpu_res_if.source res_o
);
  import ebcpu_pkg::*;

  typedef struct packed {
    logic [7:0] r;
    logic       c;
  } shift_t;

  function automatic logic [7:0] with_zn(input logic [7:0] p, input logic [7:0] v);
    logic [7:0] q;
    q         = p;
    q[FLAG_N] = v[7];
    q[FLAG_Z] = (v == 8'h00);
    return q;
  endfunction

  function automatic shift_t shift8(input logic [7:0] v, input logic left,
                                    input logic rot, input logic cin);
    shift_t s;
    if (left) begin
      s.c = v[7];
      s.r = {v[6:0], rot & cin};
    end else begin
      s.c = v[0];
      s.r = {rot & cin, v[7:1]};
    end
    return s;
  endfunction

  function automatic logic [7:0] pulled_status(input logic [7:0] p, input logic [7:0] m);
    return {m[7:6], 1'b1, p[FLAG_B], m[3:0]};
  endfunction

  in_word_t   in_q;
  logic       in_valid_q, in_valid_d;
  res_word_t  res_q, res_d;
  logic       res_valid_q, res_valid_d;
  logic [7:0] a_q, a_d, x_q, x_d, y_q, y_d, s_q, s_d, p_q, p_d;
  logic [15:0] pc_d;
  logic       exec_go;

  logic [7:0]  m;
  logic [7:0]  add_m;
  logic [8:0]  sum;
  logic [7:0]  cmp_reg;
  logic [8:0]  diff;
  logic [15:0] ret_addr;
  logic        take;
  shift_t      sh;
  logic [1:0]  wc;
  logic [15:0] wa, wd;

  assign exec_go     = in_valid_q && (!res_valid_q || res_o.ready);
  assign in_i.ready  = !in_valid_q || exec_go;
  assign res_o.valid = res_valid_q;
  assign res_o.data  = res_q;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_i.valid && in_i.ready) begin
      in_valid_d = 1'b1;
    end else if (exec_go) begin
      in_valid_d = 1'b0;
    end
    res_valid_d = res_valid_q;
    if (exec_go) begin
      res_valid_d = 1'b1;
    end else if (res_o.ready) begin
      res_valid_d = 1'b0;
    end
  end

  always_comb begin
    m        = in_q.read_data[7:0];
    add_m    = (op_e'(in_q.operation) == OP_SBC) ? ~m : m;
    sum      = {1'b0, a_q} + {1'b0, add_m} + {8'h00, p_q[FLAG_C]};
    cmp_reg  = (op_e'(in_q.operation) == OP_CPX) ? x_q :
               (op_e'(in_q.operation) == OP_CPY) ? y_q : a_q;
    diff     = {1'b0, cmp_reg} - {1'b0, m};
    ret_addr = in_q.next_pc - 16'd1;
    sh       = shift8(m, 1'b0, 1'b0, 1'b0);

    a_d  = a_q;
    x_d  = x_q;
    y_d  = y_q;
    s_d  = s_q;
    p_d  = p_q;
    pc_d = in_q.next_pc;
    wc   = WRITE_NONE;
    wa   = 16'h0000;
    wd   = 16'h0000;
    take = 1'b0;

    unique case (op_e'(in_q.operation)) inside
      OP_LDA: begin a_d = m; p_d = with_zn(p_q, m); end
      OP_LDX: begin x_d = m; p_d = with_zn(p_q, m); end
      OP_LDY: begin y_d = m; p_d = with_zn(p_q, m); end
      OP_STA: begin wc = WRITE_ONE; wa = in_q.address; wd = {8'h00, a_q}; end
      OP_STX: begin wc = WRITE_ONE; wa = in_q.address; wd = {8'h00, x_q}; end
      OP_STY: begin wc = WRITE_ONE; wa = in_q.address; wd = {8'h00, y_q}; end
      OP_TAX: begin x_d = a_q; p_d = with_zn(p_q, a_q); end
      OP_TAY: begin y_d = a_q; p_d = with_zn(p_q, a_q); end
      OP_TXA: begin a_d = x_q; p_d = with_zn(p_q, x_q); end
      OP_TYA: begin a_d = y_q; p_d = with_zn(p_q, y_q); end
      OP_TSX: begin x_d = s_q; p_d = with_zn(p_q, s_q); end
      OP_TXS: s_d = x_q;
      OP_PHA: begin
        wc  = WRITE_ONE;
        wa  = {STACK_PAGE, s_q};
        wd  = {8'h00, a_q};
        s_d = s_q - 8'd1;
      end
      OP_PHP: begin
        wc  = WRITE_ONE;
        wa  = {STACK_PAGE, s_q};
        wd  = {8'h00, p_q | PUSH_FLAG_MASK};
        s_d = s_q - 8'd1;
      end
      OP_PLA: begin s_d = s_q + 8'd1; a_d = m; p_d = with_zn(p_q, m); end
      OP_PLP: begin s_d = s_q + 8'd1; p_d = pulled_status(p_q, m); end
      OP_AND: begin a_d = a_q & m; p_d = with_zn(p_q, a_q & m); end
      OP_EOR: begin a_d = a_q ^ m; p_d = with_zn(p_q, a_q ^ m); end
      OP_ORA: begin a_d = a_q | m; p_d = with_zn(p_q, a_q | m); end
      OP_BIT: begin
        p_d[FLAG_N] = m[7];
        p_d[FLAG_V] = m[6];
        p_d[FLAG_Z] = ((a_q & m) == 8'h00);
      end
      OP_ADC, OP_SBC: begin
        a_d         = sum[7:0];
        p_d         = with_zn(p_q, sum[7:0]);
        p_d[FLAG_C] = sum[8];
        p_d[FLAG_V] = (a_q[7] ^ sum[7]) & (add_m[7] ^ sum[7]);
      end
      OP_CMP, OP_CPX, OP_CPY: begin
        p_d         = with_zn(p_q, diff[7:0]);
        p_d[FLAG_C] = !diff[8];
      end
      OP_INC: begin
        wc  = WRITE_ONE;
        wa  = in_q.address;
        wd  = {8'h00, m + 8'd1};
        p_d = with_zn(p_q, m + 8'd1);
      end
      OP_DEC: begin
        wc  = WRITE_ONE;
        wa  = in_q.address;
        wd  = {8'h00, m - 8'd1};
        p_d = with_zn(p_q, m - 8'd1);
      end
      OP_INX: begin x_d = x_q + 8'd1; p_d = with_zn(p_q, x_q + 8'd1); end
      OP_INY: begin y_d = y_q + 8'd1; p_d = with_zn(p_q, y_q + 8'd1); end
      OP_DEX: begin x_d = x_q - 8'd1; p_d = with_zn(p_q, x_q - 8'd1); end
      OP_DEY: begin y_d = y_q - 8'd1; p_d = with_zn(p_q, y_q - 8'd1); end
      OP_ASLA, OP_LSRA, OP_ROLA, OP_RORA: begin
        sh = shift8(a_q,
                    (op_e'(in_q.operation) == OP_ASLA) || (op_e'(in_q.operation) == OP_ROLA),
                    (op_e'(in_q.operation) == OP_ROLA) || (op_e'(in_q.operation) == OP_RORA),
                    p_q[FLAG_C]);
        a_d         = sh.r;
        p_d         = with_zn(p_q, sh.r);
        p_d[FLAG_C] = sh.c;
      end
      OP_ASLM, OP_LSRM, OP_ROLM, OP_RORM: begin
        sh = shift8(m,
                    (op_e'(in_q.operation) == OP_ASLM) || (op_e'(in_q.operation) == OP_ROLM),
                    (op_e'(in_q.operation) == OP_ROLM) || (op_e'(in_q.operation) == OP_RORM),
                    p_q[FLAG_C]);
        wc          = WRITE_ONE;
        wa          = in_q.address;
        wd          = {8'h00, sh.r};
        p_d         = with_zn(p_q, sh.r);
        p_d[FLAG_C] = sh.c;
      end
      OP_JMP: pc_d = in_q.address;
      OP_JSR: begin
        wc   = WRITE_TWO;
        wa   = {STACK_PAGE, s_q};
        wd   = {ret_addr[7:0], ret_addr[15:8]};
        s_d  = s_q - 8'd2;
        pc_d = in_q.address;
      end
      OP_RTS: begin
        s_d  = s_q + 8'd2;
        pc_d = in_q.read_data[15:0] + 16'd1;
      end
      OP_BCC: take = !p_q[FLAG_C];
      OP_BCS: take = p_q[FLAG_C];
      OP_BNE: take = !p_q[FLAG_Z];
      OP_BEQ: take = p_q[FLAG_Z];
      OP_BPL: take = !p_q[FLAG_N];
      OP_BMI: take = p_q[FLAG_N];
      OP_BVC: take = !p_q[FLAG_V];
      OP_BVS: take = p_q[FLAG_V];
      OP_CLC: p_d[FLAG_C] = 1'b0;
      OP_CLD: p_d[FLAG_D] = 1'b0;
      OP_CLI: p_d[FLAG_I] = 1'b0;
      OP_CLV: p_d[FLAG_V] = 1'b0;
      OP_SEC: p_d[FLAG_C] = 1'b1;
      OP_SED: p_d[FLAG_D] = 1'b1;
      OP_SEI: p_d[FLAG_I] = 1'b1;
      OP_BRK: p_d[FLAG_B] = 1'b1;
      OP_RTI: begin
        s_d  = s_q + 8'd3;
        p_d  = pulled_status(p_q, m);
        pc_d = in_q.read_data[23:8];
      end
      default: begin
      end
    endcase

    if (take) begin
      pc_d = in_q.address;
    end

    res_d.write_count         = wc;
    res_d.write_address       = wa;
    res_d.write_data          = wd;
    res_d.accumulator_out     = a_d;
    res_d.index_x_out         = x_d;
    res_d.index_y_out         = y_d;
    res_d.stack_pointer_out   = s_d;
    res_d.status_out          = p_d;
    res_d.program_counter_out = pc_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
      a_q         <= 8'h00;
      x_q         <= 8'h00;
      y_q         <= 8'h00;
      s_q         <= SP_RESET;
      p_q         <= STATUS_RESET;
    end else begin
      in_valid_q  <= in_valid_d;
      res_valid_q <= res_valid_d;
      if (exec_go) begin
        a_q <= a_d;
        x_q <= x_d;
        y_q <= y_d;
        s_q <= s_d;
        p_q <= p_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_q <= in_i.data;
    end
    if (exec_go) begin
      res_q <= res_d;
    end
  end

endmodule

// ===== hdl/ebcpu_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ebcpu_checker
// Port-level checks of the execute unit, bound to the execute unit module.
// ----------------------------------------------------------------------------
module ebcpu_checker (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  res_valid_i,
  input logic                  res_ready_i,
  input ebcpu_pkg::res_word_t  res_data_i
);
  import ebcpu_pkg::*;

  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(res_data_i))
    else $error("Result word changed while stalled.");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> res_data_i.write_count != 2'd3)
    else $error("Write count out of range.");

  a_no_write_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_data_i.write_count == WRITE_NONE |->
      res_data_i.write_address == 16'h0000 && res_data_i.write_data == 16'h0000)
    else $error("Write fields not cleared without a write.");

  a_single_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_data_i.write_count == WRITE_ONE |->
      res_data_i.write_data[15:8] == 8'h00)
    else $error("Upper write byte set on a single-byte write.");

  a_unused_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> res_data_i.status_out[FLAG_U])
    else $error("Status bit 5 cleared.");

endmodule

bind eight_bit_cpu_execute_unit ebcpu_checker u_ebcpu_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .res_valid_i (res_o.valid),
  .res_ready_i (res_o.ready),
  .res_data_i  (res_o.data)
);

// ===== bench/eight_bit_cpu_execute_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eight_bit_cpu_execute_unit_tb
// Self-checking bench for the 6502-style execute unit.
// ----------------------------------------------------------------------------
// A short table of decoded instructions comes first. It covers the reset
// state, field extremes, stack pushes and pulls, the B and bit 5 rules,
// overflow, compares, read-modify-write, JSR, RTS, RTI, branches and an
// unused code. About 700 random instructions follow in three idle profiles.
// A local model of A, X, Y, S, P and PC predicts every retired word. Each
// retired word is compared field by field with the oldest queued expectation.
// ----------------------------------------------------------------------------
module eight_bit_cpu_execute_unit_tb;
  import ebcpu_pkg::*;

  localparam int         PHASE_WORDS     = 234;
  localparam int         HOLD_OFF_CYCLES = 80;
  localparam int         DRAIN_CYCLES    = 8;
  localparam int         STALL_LIMIT     = 2000;
  localparam logic [5:0] OP_CODE_LAST    = 6'h3F;

  typedef enum int {PH_DIRECTED, PH_SLOW_RETIRE, PH_SLOW_ISSUE, PH_NO_IDLE} phase_e;

  typedef struct {
    in_word_t  instr;
    bit        typed;
    res_word_t want;
  } instr_row_t;

  localparam int N_DIRECTED = 28;

  logic clk_i;
  logic rst_ni;

  ebcpu_in_if  instr_ch ();
  ebcpu_res_if retire_ch ();

  eight_bit_cpu_execute_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (instr_ch),
    .res_o  (retire_ch)
  );

  logic [7:0]  acc_q;
  logic [7:0]  x_q;
  logic [7:0]  y_q;
  logic [7:0]  sp_q;
  logic [7:0]  status_q;
  logic [15:0] pc_q;

  res_word_t pending_retires[$];
  int        bad_field_count = 0;
  int        send_idle_pct   = 0;
  int        recv_idle_pct   = 0;
  phase_e    phase           = PH_DIRECTED;
  bit        held_off        = 1'b0;
  int        quiet_cycles    = 0;

  instr_row_t directed_rows [N_DIRECTED] = '{
    '{'{OP_NOP, 16'h0000, 24'h000000, 16'h0001}, 1'b1,
      '{WRITE_NONE, 16'h0000, 16'h0000, 8'h00, 8'h00, 8'h00, 8'hFD, 8'h24, 16'h0001}},
    '{'{OP_LDA, 16'h0000, 24'h000080, 16'h0002}, 1'b1,
      '{WRITE_NONE, 16'h0000, 16'h0000, 8'h80, 8'h00, 8'h00, 8'hFD, 8'hA4, 16'h0002}},
    '{'{OP_LDA, 16'h0000, 24'hFFFF00, 16'h0003}, 1'b1,
      '{WRITE_NONE, 16'h0000, 16'h0000, 8'h00, 8'h00, 8'h00, 8'hFD, 8'h26, 16'h0003}},
    '{'{OP_LDX, 16'h0000, 24'h0000FF, 16'hFFFF}, 1'b1,
      '{WRITE_NONE, 16'h0000, 16'h0000, 8'h00, 8'hFF, 8'h00, 8'hFD, 8'hA4, 16'hFFFF}},
    '{'{OP_STX, 16'hFFFF, 24'h000000, 16'h0000}, 1'b1,
      '{WRITE_ONE, 16'hFFFF, 16'h00FF, 8'h00, 8'hFF, 8'h00, 8'hFD, 8'hA4, 16'h0000}},
    '{'{OP_TXS, 16'h0000, 24'h000000, 16'h0001}, 1'b0, '0},
    '{'{OP_PHA, 16'h0000, 24'h000000, 16'h0002}, 1'b0, '0},
    '{'{OP_PHP, 16'h0000, 24'h000000, 16'h0003}, 1'b0, '0},
    '{'{OP_PLP, 16'h0000, 24'hFFFFFF, 16'h0004}, 1'b0, '0},
    '{'{OP_BRK, 16'h0000, 24'h000000, 16'h0005}, 1'b0, '0},
    '{'{OP_PLP, 16'h0000, 24'h000000, 16'h0006}, 1'b0, '0},
    '{'{OP_LDA, 16'h0000, 24'h00007F, 16'h0007}, 1'b0, '0},
    '{'{OP_ADC, 16'h0000, 24'h000001, 16'h0008}, 1'b0, '0},
    '{'{OP_SBC, 16'h0000, 24'h000000, 16'h0009}, 1'b0, '0},
    '{'{OP_SEC, 16'h0000, 24'h000000, 16'h000A}, 1'b0, '0},
    '{'{OP_CMP, 16'h0000, 24'h00007F, 16'h000B}, 1'b0, '0},
    '{'{OP_BIT, 16'h0000, 24'h0000C0, 16'h000C}, 1'b0, '0},
    '{'{OP_INC, 16'h1234, 24'h0000FF, 16'h000D}, 1'b0, '0},
    '{'{OP_DEC, 16'h8000, 24'h000000, 16'h000E}, 1'b0, '0},
    '{'{OP_RORA, 16'h0000, 24'h000000, 16'h000F}, 1'b0, '0},
    '{'{OP_LSRM, 16'h00FF, 24'h000001, 16'h0010}, 1'b0, '0},
    '{'{OP_ROLM, 16'h0100, 24'h000080, 16'h0011}, 1'b0, '0},
    '{'{OP_JSR, 16'hABCD, 24'h000000, 16'h0000}, 1'b0, '0},
    '{'{OP_RTS, 16'h0000, 24'h00FFFF, 16'h0012}, 1'b0, '0},
    '{'{OP_RTI, 16'h0000, 24'hFFFFFF, 16'h0013}, 1'b0, '0},
    '{'{OP_BEQ, 16'h4321, 24'h000000, 16'h0014}, 1'b0, '0},
    '{'{OP_BNE, 16'h5555, 24'h000000, 16'h0015}, 1'b0, '0},
    '{'{OP_CODE_LAST, 16'hFFFF, 24'hFFFFFF, 16'hFFFF}, 1'b0, '0}
  };

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic logic [7:0] with_nz(input logic [7:0] p, input logic [7:0] v);
    logic [7:0] q;
    q         = p;
    q[FLAG_Z] = (v == 8'h00);
    q[FLAG_N] = v[7];
    return q;
  endfunction

  function automatic logic [7:0] add_carry(input logic [7:0] a, input logic [7:0] m,
                                           inout logic [7:0] p);
    logic [8:0] sum;
    sum       = {1'b0, a} + {1'b0, m} + {8'h00, p[FLAG_C]};
    p[FLAG_C] = sum[8];
    p[FLAG_V] = (a[7] == m[7]) && (sum[7] != a[7]);
    p         = with_nz(p, sum[7:0]);
    return sum[7:0];
  endfunction

  // Kind bit 0 selects a right shift, bit 1 feeds the carry in.
  function automatic logic [7:0] shift_value(input logic [7:0] v, input logic [1:0] kind,
                                             inout logic [7:0] p);
    logic [7:0] r;
    if (!kind[0]) begin
      r         = {v[6:0], kind[1] & p[FLAG_C]};
      p[FLAG_C] = v[7];
    end else begin
      r         = {kind[1] & p[FLAG_C], v[7:1]};
      p[FLAG_C] = v[0];
    end
    p = with_nz(p, r);
    return r;
  endfunction

  function automatic logic [7:0] compare_flags(input logic [7:0] r, input logic [7:0] m,
                                               input logic [7:0] p);
    logic [7:0] q;
    q         = p;
    q[FLAG_C] = (r >= m);
    return with_nz(q, r - m);
  endfunction

  function automatic logic [7:0] pulled_status(input logic [7:0] old, input logic [7:0] b);
    logic [7:0] q;
    q         = b;
    q[FLAG_U] = 1'b1;
    q[FLAG_B] = old[FLAG_B];
    return q;
  endfunction

  function automatic res_word_t execute_instruction(input in_word_t w);
    res_word_t   r;
    logic [7:0]  m, a, x, y, s, p, v;
    logic [15:0] pc, ret;
    logic        take;
    r    = '0;
    m    = w.read_data[7:0];
    a    = acc_q;
    x    = x_q;
    y    = y_q;
    s    = sp_q;
    p    = status_q;
    pc   = w.next_pc;
    take = 1'b0;
    case (w.operation)
      OP_LDA: begin a = m; p = with_nz(p, a); end
      OP_LDX: begin x = m; p = with_nz(p, x); end
      OP_LDY: begin y = m; p = with_nz(p, y); end
      OP_STA: begin
        r.write_count = WRITE_ONE; r.write_address = w.address; r.write_data = {8'h00, a};
      end
      OP_STX: begin
        r.write_count = WRITE_ONE; r.write_address = w.address; r.write_data = {8'h00, x};
      end
      OP_STY: begin
        r.write_count = WRITE_ONE; r.write_address = w.address; r.write_data = {8'h00, y};
      end
      OP_TAX: begin x = a; p = with_nz(p, x); end
      OP_TAY: begin y = a; p = with_nz(p, y); end
      OP_TXA: begin a = x; p = with_nz(p, a); end
      OP_TYA: begin a = y; p = with_nz(p, a); end
      OP_TSX: begin x = s; p = with_nz(p, x); end
      OP_TXS: s = x;
      OP_PHA: begin
        r.write_count = WRITE_ONE; r.write_address = {STACK_PAGE, s};
        r.write_data  = {8'h00, a};
        s = s - 8'd1;
      end
      OP_PHP: begin
        r.write_count = WRITE_ONE; r.write_address = {STACK_PAGE, s};
        r.write_data  = {8'h00, p | PUSH_FLAG_MASK};
        s = s - 8'd1;
      end
      OP_PLA: begin s = s + 8'd1; a = m; p = with_nz(p, a); end
      OP_PLP: begin s = s + 8'd1; p = pulled_status(p, m); end
      OP_AND: begin a = a & m; p = with_nz(p, a); end
      OP_EOR: begin a = a ^ m; p = with_nz(p, a); end
      OP_ORA: begin a = a | m; p = with_nz(p, a); end
      OP_BIT: begin
        p[FLAG_N] = m[7];
        p[FLAG_V] = m[6];
        p[FLAG_Z] = ((a & m) == 8'h00);
      end
      OP_ADC: a = add_carry(a, m, p);
      OP_SBC: a = add_carry(a, ~m, p);
      OP_CMP: p = compare_flags(a, m, p);
      OP_CPX: p = compare_flags(x, m, p);
      OP_CPY: p = compare_flags(y, m, p);
      OP_INC, OP_DEC: begin
        v = (w.operation == OP_INC) ? m + 8'd1 : m - 8'd1;
        r.write_count = WRITE_ONE; r.write_address = w.address; r.write_data = {8'h00, v};
        p = with_nz(p, v);
      end
      OP_INX: begin x = x + 8'd1; p = with_nz(p, x); end
      OP_INY: begin y = y + 8'd1; p = with_nz(p, y); end
      OP_DEX: begin x = x - 8'd1; p = with_nz(p, x); end
      OP_DEY: begin y = y - 8'd1; p = with_nz(p, y); end
      OP_ASLA, OP_LSRA, OP_ROLA, OP_RORA: a = shift_value(a, 2'(w.operation - OP_ASLA), p);
      OP_ASLM, OP_LSRM, OP_ROLM, OP_RORM: begin
        v = shift_value(m, 2'(w.operation - OP_ASLM), p);
        r.write_count = WRITE_ONE; r.write_address = w.address; r.write_data = {8'h00, v};
      end
      OP_JMP: pc = w.address;
      OP_JSR: begin
        ret = w.next_pc - 16'd1;
        r.write_count = WRITE_TWO; r.write_address = {STACK_PAGE, s};
        r.write_data  = {ret[7:0], ret[15:8]};
        s  = s - 8'd2;
        pc = w.address;
      end
      OP_RTS: begin s = s + 8'd2; pc = w.read_data[15:0] + 16'd1; end
      OP_BCC: take = !p[FLAG_C];
      OP_BCS: take = p[FLAG_C];
      OP_BNE: take = !p[FLAG_Z];
      OP_BEQ: take = p[FLAG_Z];
      OP_BPL: take = !p[FLAG_N];
      OP_BMI: take = p[FLAG_N];
      OP_BVC: take = !p[FLAG_V];
      OP_BVS: take = p[FLAG_V];
      OP_CLC: p[FLAG_C] = 1'b0;
      OP_CLD: p[FLAG_D] = 1'b0;
      OP_CLI: p[FLAG_I] = 1'b0;
      OP_CLV: p[FLAG_V] = 1'b0;
      OP_SEC: p[FLAG_C] = 1'b1;
      OP_SED: p[FLAG_D] = 1'b1;
      OP_SEI: p[FLAG_I] = 1'b1;
      OP_BRK: p[FLAG_B] = 1'b1;
      OP_RTI: begin
        s  = s + 8'd3;
        p  = pulled_status(p, m);
        pc = w.read_data[23:8];
      end
      default: ;
    endcase
    if (take) pc = w.address;
    acc_q    = a;
    x_q      = x;
    y_q      = y;
    sp_q     = s;
    status_q = p;
    pc_q     = pc;
    r.accumulator_out     = a;
    r.index_x_out         = x;
    r.index_y_out         = y;
    r.stack_pointer_out   = s;
    r.status_out          = p;
    r.program_counter_out = pc;
    return r;
  endfunction

  function automatic in_word_t random_instruction();
    in_word_t w;
    w.operation = 6'($urandom_range(int'(OP_CODE_LAST)));
    w.address   = 16'($urandom);
    w.read_data = 24'($urandom);
    w.next_pc   = 16'($urandom);
    if ($urandom_range(3) == 0) begin
      case ($urandom_range(3))
        0:       w.read_data[7:0] = 8'h00;
        1:       w.read_data[7:0] = 8'h7F;
        2:       w.read_data[7:0] = 8'h80;
        default: w.read_data[7:0] = 8'hFF;
      endcase
    end
    return w;
  endfunction

  task automatic issue_instruction(input in_word_t w, input bit typed, input res_word_t want);
    res_word_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      instr_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    instr_ch.valid <= 1'b1;
    instr_ch.data  <= w;
    @(posedge clk_i);
    while (!instr_ch.ready) @(posedge clk_i);
    predicted = execute_instruction(w);
    pending_retires.push_back(typed ? want : predicted);
  endtask

  task automatic drain_retires();
    instr_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_retires.size() != 0) @(posedge clk_i);
  endtask

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h, got %h", $time, name, want, got);
      bad_field_count++;
    end
  endfunction

  initial begin
    rst_ni         <= 1'b0;
    instr_ch.valid <= 1'b0;
    instr_ch.data  <= '0;
    acc_q    = 8'h00;
    x_q      = 8'h00;
    y_q      = 8'h00;
    sp_q     = SP_RESET;
    status_q = STATUS_RESET;
    pc_q     = 16'h0000;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      issue_instruction(directed_rows[i].instr, directed_rows[i].typed, directed_rows[i].want);
    end
    drain_retires();

    for (int ph = PH_SLOW_RETIRE; ph <= PH_NO_IDLE; ph++) begin
      phase = phase_e'(ph);
      case (phase)
        PH_SLOW_RETIRE: begin send_idle_pct = 18; recv_idle_pct = 86; end
        PH_SLOW_ISSUE:  begin send_idle_pct = 86; recv_idle_pct = 18; end
        default:        begin send_idle_pct = 0;  recv_idle_pct = 0;  end
      endcase
      repeat (PHASE_WORDS) issue_instruction(random_instruction(), 1'b0, '0);
      drain_retires();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (bad_field_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // In the last phase the retire side stops once for a long stretch while
  // instructions keep coming, so the unit fills and back-pressures its input.
  initial begin
    retire_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (phase == PH_NO_IDLE && !held_off) begin
        held_off = 1'b1;
        retire_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
      end
      retire_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin : retire_check
    res_word_t want;
    if (rst_ni && retire_ch.valid && retire_ch.ready) begin
      if (pending_retires.size() == 0) begin
        $display("%0t: unexpected word, got %h", $time, retire_ch.data);
        bad_field_count++;
      end else begin
        want = pending_retires.pop_front();
        check_field("write_count", 16'(want.write_count), 16'(retire_ch.data.write_count));
        check_field("write_address", want.write_address, retire_ch.data.write_address);
        check_field("write_data", want.write_data, retire_ch.data.write_data);
        check_field("accumulator_out", 16'(want.accumulator_out),
                    16'(retire_ch.data.accumulator_out));
        check_field("index_x_out", 16'(want.index_x_out), 16'(retire_ch.data.index_x_out));
        check_field("index_y_out", 16'(want.index_y_out), 16'(retire_ch.data.index_y_out));
        check_field("stack_pointer_out", 16'(want.stack_pointer_out),
                    16'(retire_ch.data.stack_pointer_out));
        check_field("status_out", 16'(want.status_out), 16'(retire_ch.data.status_out));
        check_field("program_counter_out", want.program_counter_out,
                    retire_ch.data.program_counter_out);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (instr_ch.valid && instr_ch.ready) ||
        (retire_ch.valid && retire_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

// ===== eight_bit_cpu_execute_unit.f =====
hdl/ebcpu_pkg.sv
hdl/ebcpu_if.sv
hdl/eight_bit_cpu_execute_unit.sv
hdl/ebcpu_checker.sv
bench/eight_bit_cpu_execute_unit_tb.sv
